// ===== rtl/core/rfr_pkg.sv =====
package rfr_pkg;

   // Field and internal widths. Q formats: inputs Q1.14, eta Q2.14, outputs Q5.14.
   localparam int COMP_W    = 16;  // incident and normal components
   localparam int ETA_W     = 16;  // refraction ratio
   localparam int OUT_W     = 20;  // refracted components
   localparam int FRAC_BITS = 14;

   localparam int PROD_W    = 32;  // one I*N product
   localparam int DOT_W     = 34;  // sum of three products, scale 2^28
   localparam int C_W       = 19;  // dot product at scale 2^14
   localparam int E_W       = 18;  // eta squared at scale 2^14
   localparam int CSQ_W     = 36;  // c14 squared, never negative
   localparam int HALF_W    = 18;  // half of CSQ_W, one partial product operand
   localparam int PART_W    = 36;  // e14 times one half of c14 squared
   localparam int P_W       = 54;  // e14 times c14 squared
   localparam int BASE_W    = 33;  // 2^28 - e14 * 2^14
   localparam int K_W       = 41;  // k at scale 2^28, signed
   localparam int RAD_W     = 40;  // square root operand
   localparam int ROOT_W    = 20;  // square root result
   localparam int REM_W     = 22;  // square root partial remainder
   localparam int ETAI_W    = 33;  // eta times one incident component
   localparam int EC_W      = 36;  // eta times c14
   localparam int M_W       = 37;  // eta*c14 + sqrt(k)*2^14
   localparam int MN_W      = 53;  // m times one normal component
   localparam int V_W       = 53;  // eta*I*2^14 - m*N, scale 2^42
   localparam int SH_W      = V_W - 2 * FRAC_BITS;  // after the final floor

   // Square root: four result bits are resolved in each pipeline stage.
   localparam int SQRT_STEPS  = 4;
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

   typedef struct packed {
      logic signed [COMP_W-1:0] incident_x;
      logic signed [COMP_W-1:0] incident_y;
      logic signed [COMP_W-1:0] incident_z;
      logic signed [COMP_W-1:0] normal_x;
      logic signed [COMP_W-1:0] normal_y;
      logic signed [COMP_W-1:0] normal_z;
      logic [ETA_W-1:0]         index_ratio;
   } rfr_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] refracted_x;
      logic signed [OUT_W-1:0] refracted_y;
      logic signed [OUT_W-1:0] refracted_z;
      logic                    internal_reflection;
   } rfr_rsp_type;

   // Values that ride alongside the square root.
   typedef struct packed {
      logic [2:0][ETAI_W-1:0]  eta_inc;
      logic [2:0][COMP_W-1:0]  normal;
      logic signed [EC_W-1:0]  eta_dot;
      logic                    tir;
   } rfr_side_type;

   typedef struct packed {
      logic [RAD_W-1:0] radicand;
      rfr_side_type     side;
   } rfr_root_req_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      rfr_side_type      side;
   } rfr_root_rsp_type;

endpackage

// ===== rtl/core/rfr_pipe_ctrl.sv =====
module rfr_pipe_ctrl #(
   parameter int STAGES = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [STAGES-1:0] load
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;

   // A stage loads when it is empty or its content moves on this cycle.
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in[0] = in_valid;
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (load[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign in_ready  = load[0];
   assign out_valid = valid_ff[STAGES-1];

endmodule

// ===== rtl/core/rfr_front.sv =====
module rfr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rfr_pkg::rfr_req_type      in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rfr_pkg::rfr_root_req_type out_data
);
   import rfr_pkg::*;

   localparam int STAGES = 6;
   localparam logic [BASE_W-1:0] ONE_Q28  = BASE_W'(1) << (2 * FRAC_BITS);
   localparam logic [P_W-1:0]    ROUND_UP = {{(P_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

   logic [STAGES-1:0] load;

   rfr_pipe_ctrl #(
      .STAGES (STAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .load      (load)
   );

   // Stage 1: component products, eta squared, eta times I.
   logic signed [COMP_W-1:0] inc [3];
   logic signed [COMP_W-1:0] nrm [3];
   logic signed [PROD_W-1:0] dot_in [3];
   logic signed [PROD_W-1:0] dot1_ff [3];
   logic [2*ETA_W-1:0]       ee_in;
   logic [2*ETA_W-1:0]       ee1_ff;
   logic [ETA_W-1:0]         eta1_ff;
   rfr_side_type             side_in;
   rfr_side_type             side1_ff;

   assign inc[0] = in_data.incident_x;
   assign inc[1] = in_data.incident_y;
   assign inc[2] = in_data.incident_z;
   assign nrm[0] = in_data.normal_x;
   assign nrm[1] = in_data.normal_y;
   assign nrm[2] = in_data.normal_z;

   always_comb begin
      side_in = '0;
      for (int j = 0; j < 3; j++) begin
         dot_in[j]         = inc[j] * nrm[j];
         side_in.eta_inc[j] = $signed({1'b0, in_data.index_ratio}) * inc[j];
         side_in.normal[j]  = nrm[j];
      end
      ee_in = in_data.index_ratio * in_data.index_ratio;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         for (int j = 0; j < 3; j++) begin
            dot1_ff[j] <= dot_in[j];
         end
         ee1_ff   <= ee_in;
         eta1_ff  <= in_data.index_ratio;
         side1_ff <= side_in;
      end
   end

   // Stage 2: c = dot(N,I) floored to scale 2^14, eta^2 floored to 2^14.
   logic signed [DOT_W-1:0] c28;
   logic signed [C_W-1:0]   c14_2_ff;
   logic [E_W-1:0]          e14_2_ff;
   logic [ETA_W-1:0]        eta2_ff;
   rfr_side_type            side2_ff;

   assign c28 = dot1_ff[0] + dot1_ff[1] + dot1_ff[2];

   always_ff @(posedge clock) begin
      if (load[1]) begin
         c14_2_ff <= c28[FRAC_BITS+C_W-1:FRAC_BITS];
         e14_2_ff <= ee1_ff[2*ETA_W-1:FRAC_BITS];
         eta2_ff  <= eta1_ff;
         side2_ff <= side1_ff;
      end
   end

   // Stage 3: c squared, eta*c, and the constant part of k.
   logic signed [2*C_W-1:0] csq_full;
   logic [CSQ_W-1:0]        csq3_ff;
   logic [E_W-1:0]          e14_3_ff;
   logic [BASE_W-1:0]       base3_ff;
   rfr_side_type            side3_in;
   rfr_side_type            side3_ff;

   always_comb begin
      csq_full         = c14_2_ff * c14_2_ff;
      side3_in         = side2_ff;
      side3_in.eta_dot = $signed({1'b0, eta2_ff}) * c14_2_ff;
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         csq3_ff  <= csq_full[CSQ_W-1:0];
         e14_3_ff <= e14_2_ff;
         base3_ff <= ONE_Q28 - {1'b0, e14_2_ff, {FRAC_BITS{1'b0}}};
         side3_ff <= side3_in;
      end
   end

   // Stage 4: eta^2 * c^2 as two partial products.
   logic [PART_W-1:0] plo4_ff;
   logic [PART_W-1:0] phi4_ff;
   logic [BASE_W-1:0] base4_ff;
   rfr_side_type      side4_ff;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         plo4_ff  <= e14_3_ff * csq3_ff[HALF_W-1:0];
         phi4_ff  <= e14_3_ff * csq3_ff[CSQ_W-1:HALF_W];
         base4_ff <= base3_ff;
         side4_ff <= side3_ff;
      end
   end

   // Stage 5: join the partial products; the rounding constant turns the
   // later shift into a ceiling, which floors the negated term.
   logic [P_W-1:0]    psum5_ff;
   logic [BASE_W-1:0] base5_ff;
   rfr_side_type      side5_ff;

   always_ff @(posedge clock) begin
      if (load[4]) begin
         psum5_ff <= {phi4_ff, {HALF_W{1'b0}}} + P_W'(plo4_ff) + ROUND_UP;
         base5_ff <= base4_ff;
         side5_ff <= side4_ff;
      end
   end

   // Stage 6: k = 1 - eta^2 (1 - c^2); a negative k means total reflection.
   logic signed [K_W-1:0] k28;
   rfr_root_req_type      out_in;
   rfr_root_req_type      out_ff;

   always_comb begin
      k28              = $signed(base5_ff) + $signed({1'b0, psum5_ff[P_W-1:FRAC_BITS]});
      out_in.side      = side5_ff;
      out_in.side.tir  = k28[K_W-1];
      out_in.radicand  = k28[K_W-1] ? '0 : k28[RAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load[5]) begin
         out_ff <= out_in;
      end
   end

   assign out_data = out_ff;

endmodule

// ===== rtl/core/rfr_sqrt.sv =====
module rfr_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rfr_pkg::rfr_root_req_type in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rfr_pkg::rfr_root_rsp_type out_data
);
   import rfr_pkg::*;

   logic [SQRT_STAGES-1:0] load;

   rfr_pipe_ctrl #(
      .STAGES (SQRT_STAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .load      (load)
   );

   logic [RAD_W-1:0]  rad_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];
   logic [REM_W-1:0]  rem_ff  [SQRT_STAGES];
   rfr_side_type      side_ff [SQRT_STAGES];

   // Restoring square root, two radicand bits per result bit.
   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      logic [RAD_W-1:0]  rad_src;
      logic [ROOT_W-1:0] root_src;
      logic [ROOT_W-1:0] root_in;
      logic [REM_W-1:0]  rem_src;
      logic [REM_W-1:0]  rem_in;
      rfr_side_type      side_src;

      if (s == 0) begin : g_first
         assign rad_src  = in_data.radicand;
         assign root_src = '0;
         assign rem_src  = '0;
         assign side_src = in_data.side;
      end else begin : g_next
         assign rad_src  = rad_ff[s-1];
         assign root_src = root_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      always_comb begin : digit_steps
         logic [REM_W+1:0]  rem_try;
         logic [REM_W+1:0]  trial;
         logic [ROOT_W-1:0] root;
         logic [REM_W-1:0]  rem;
         root = root_src;
         rem  = rem_src;
         for (int t = 0; t < SQRT_STEPS; t++) begin
            rem_try = {rem, rad_src[RAD_W-1-2*(s*SQRT_STEPS+t) -: 2]};
            trial   = (REM_W+2)'({root, 2'b01});
            if (rem_try >= trial) begin
               rem  = REM_W'(rem_try - trial);
               root = {root[ROOT_W-2:0], 1'b1};
            end else begin
               rem  = REM_W'(rem_try);
               root = {root[ROOT_W-2:0], 1'b0};
            end
         end
         root_in = root;
         rem_in  = rem;
      end

      always_ff @(posedge clock) begin
         if (load[s]) begin
            rad_ff[s]  <= rad_src;
            root_ff[s] <= root_in;
            rem_ff[s]  <= rem_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_data.root = root_ff[SQRT_STAGES-1];
   assign out_data.side = side_ff[SQRT_STAGES-1];

endmodule

// ===== rtl/core/rfr_back.sv =====
module rfr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rfr_pkg::rfr_root_rsp_type in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rfr_pkg::rfr_rsp_type      out_data
);
   import rfr_pkg::*;

   localparam int STAGES = 3;
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   logic [STAGES-1:0] load;

   rfr_pipe_ctrl #(
      .STAGES (STAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_ready (out_ready),
      .load      (load)
   );

   // Stage 1: m = eta*c + sqrt(k), scale 2^28.
   logic signed [M_W-1:0] m1_ff;
   rfr_side_type          side1_ff;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         m1_ff    <= in_data.side.eta_dot
                     + $signed({1'b0, in_data.root, {FRAC_BITS{1'b0}}});
         side1_ff <= in_data.side;
      end
   end

   // Stage 2: m times each normal component.
   logic signed [MN_W-1:0] mn2_ff [3];
   rfr_side_type           side2_ff;

   always_ff @(posedge clock) begin
      if (load[1]) begin
         for (int j = 0; j < 3; j++) begin
            mn2_ff[j] <= m1_ff * $signed(side1_ff.normal[j]);
         end
         side2_ff <= side1_ff;
      end
   end

   // Stage 3: eta*I - m*N, floor to scale 2^14, saturate each component.
   logic signed [V_W-1:0]   diff [3];
   logic signed [SH_W-1:0]  shifted [3];
   logic signed [OUT_W-1:0] comp [3];
   rfr_rsp_type             out_in;
   rfr_rsp_type             out_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         diff[j]    = $signed({side2_ff.eta_inc[j], {FRAC_BITS{1'b0}}}) - mn2_ff[j];
         shifted[j] = diff[j][V_W-1:2*FRAC_BITS];
         if (shifted[j][SH_W-1:OUT_W-1] == '0 || shifted[j][SH_W-1:OUT_W-1] == '1) begin
            comp[j] = shifted[j][OUT_W-1:0];
         end else if (shifted[j][SH_W-1]) begin
            comp[j] = OUT_MIN;
         end else begin
            comp[j] = OUT_MAX;
         end
      end
      if (side2_ff.tir) begin
         out_in.refracted_x = '0;
         out_in.refracted_y = '0;
         out_in.refracted_z = '0;
      end else begin
         out_in.refracted_x = comp[0];
         out_in.refracted_y = comp[1];
         out_in.refracted_z = comp[2];
      end
      out_in.internal_reflection = side2_ff.tir;
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         out_ff <= out_in;
      end
   end

   assign out_data = out_ff;

endmodule

// ===== rtl/core/ray_refraction_core.sv =====
// Channel   Direction  Beat contents
// req_*     in         incident vector I, surface normal N (Q1.14), index ratio eta (Q2.14)
// rsp_*     out        refracted vector (Q5.14, saturated), internal reflection flag
//
// One beat is accepted per cycle while no stall from rsp_ready backs up the pipeline.
// The depth is six stages for the dot product and k, five stages of the square root
// (four of its twenty root bits per stage) and three for the final products and saturation.
// Reset is synchronous and clears only the stage valid bits; data registers are not reset.
// Each stage holds while the stage ahead is full and not moving, so empty stages close up
// and request beats are still taken while a result waits at rsp_ as long as a stage is free.
module ray_refraction_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rfr_pkg::rfr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rfr_pkg::rfr_rsp_type rsp_data
);
   import rfr_pkg::*;

   // Front end to square root: k is formed and checked for total reflection.
   logic             root_req_valid;
   logic             root_req_ready;
   rfr_root_req_type root_req;

   // Square root to back end: the root plus the values needed to finish.
   logic             root_rsp_valid;
   logic             root_rsp_ready;
   rfr_root_rsp_type root_rsp;

   rfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (root_req_valid),
      .out_ready (root_req_ready),
      .out_data  (root_req)
   );

   // When k is negative the radicand is zero and the flag rides in the sideband,
   // so the square root stages need no special handling.
   rfr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_req_valid),
      .in_ready  (root_req_ready),
      .in_data   (root_req),
      .out_valid (root_rsp_valid),
      .out_ready (root_rsp_ready),
      .out_data  (root_rsp)
   );

   // The last back end stage is the output register seen on rsp_.
   rfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_rsp_valid),
      .in_ready  (root_rsp_ready),
      .in_data   (root_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

// ===== rtl/core/rfr_checker.sv =====
module rfr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input rfr_pkg::rfr_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rfr_pkg::rfr_rsp_type rsp_data
);
   import rfr_pkg::*;

   // Beats accepted on req_ whose result has not yet been taken on rsp_.
   logic [4:0] pending_ff;
   logic [4:0] pending_in;

   assign pending_in = pending_ff + 5'(req_valid && req_ready) - 5'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   rsp_holds_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed or dropped while stalled");

   reflect_zero_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.internal_reflection |->
         rsp_data.refracted_x == '0 && rsp_data.refracted_y == '0 &&
         rsp_data.refracted_z == '0)
      else $error("internal reflection with a nonzero vector");

   reset_empty_a: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   no_extra_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("result beat without an accepted request");

   accept_ignored_a: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !$isunknown(req_data))
      else $error("request payload unknown at acceptance");

endmodule

bind ray_refraction_core rfr_checker u_rfr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== sim/ray_refraction_core_tb.sv =====
module ray_refraction_core_tb;

   import rfr_pkg::*;

   // Clock, reset and the two channels. Every input starts at a known value.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   rfr_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rfr_rsp_type rsp_data;

   // Surface hits waiting to be offered, and the refracted beats that the
   // accepted hits must produce, oldest first.
   rfr_req_type hit_q[$];
   rfr_rsp_type refracted_q[$];

   // Handshake flags, captured at the rising edge and consumed at the falling
   // edge, so the driver and receiver never look at ready in the same step in
   // which it may change.
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;

   int hits_sent = 0;
   int results_seen = 0;
   int mismatch_count = 0;
   int hit_gap = 0;
   int rsp_wait = 0;
   bit long_hold_done = 1'b0;

   ray_refraction_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predicts the refracted beat for one hit. All intermediate values live in
   // 64-bit signed integers, which hold every product here without overflow,
   // and an arithmetic right shift gives the floor that each narrowing step
   // calls for.
   function automatic rfr_rsp_type refracted_beat(rfr_req_type hit_in);
      longint      inc[3];
      longint      nrm[3];
      longint      eta;
      longint      dot28;
      longint      cos14;
      longint      sin_sq28;
      longint      eta_sq14;
      longint      k28;
      longint      root14;
      longint      scale28;
      longint      dir42;
      longint      comp;
      longint      trial;
      rfr_rsp_type beat;
      logic [OUT_W-1:0] comp_bits[3];

      inc[0] = $signed(hit_in.incident_x);
      inc[1] = $signed(hit_in.incident_y);
      inc[2] = $signed(hit_in.incident_z);
      nrm[0] = $signed(hit_in.normal_x);
      nrm[1] = $signed(hit_in.normal_y);
      nrm[2] = $signed(hit_in.normal_z);
      eta = longint'(hit_in.index_ratio);

      dot28 = inc[0] * nrm[0] + inc[1] * nrm[1] + inc[2] * nrm[2];
      cos14 = dot28 >>> FRAC_BITS;
      sin_sq28 = (longint'(1) << 28) - cos14 * cos14;
      eta_sq14 = (eta * eta) >>> FRAC_BITS;
      k28 = (longint'(1) << 28) - ((eta_sq14 * sin_sq28) >>> FRAC_BITS);

      beat = '0;
      if (k28 < 0) begin
         // Total internal reflection: zero vector with the flag raised.
         beat.internal_reflection = 1'b1;
         return beat;
      end

      // Truncating square root, one result bit at a time from the top. k28 is
      // below 2^41, so the root fits in 21 bits.
      root14 = 0;
      for (int b = 22; b >= 0; b--) begin
         trial = root14 | (longint'(1) << b);
         if (trial * trial <= k28)
            root14 = trial;
      end

      scale28 = eta * cos14 + root14 * 16384;
      for (int j = 0; j < 3; j++) begin
         dir42 = eta * inc[j] * 16384 - scale28 * nrm[j];
         comp = dir42 >>> 28;
         if (comp > 524287)
            comp = 524287;
         if (comp < -524288)
            comp = -524288;
         comp_bits[j] = comp[OUT_W-1:0];
      end
      beat.refracted_x = comp_bits[0];
      beat.refracted_y = comp_bits[1];
      beat.refracted_z = comp_bits[2];
      return beat;
   endfunction

   function automatic rfr_req_type hit(int ix, int iy, int iz, int nx, int ny, int nz,
                                       int eta);
      rfr_req_type item;
      item.incident_x  = ix[15:0];
      item.incident_y  = iy[15:0];
      item.incident_z  = iz[15:0];
      item.normal_x    = nx[15:0];
      item.normal_y    = ny[15:0];
      item.normal_z    = nz[15:0];
      item.index_ratio = eta[15:0];
      return item;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on beat %0d, %s: got %0d, expected %0d",
               results_seen, what, got, want);
      mismatch_count++;
   endtask

   // Request side, rising edge: note each accepted beat and queue the beat
   // that it must produce.
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         refracted_q.push_back(refracted_beat(req_data));
   end

   // Driver, falling edge. A beat that is still on offer is held unchanged.
   // Otherwise the driver idles for the gap drawn at the last acceptance, then
   // puts up the next hit. Every fourth run of 64 hits goes without gaps. When
   // a hit is taken with no gap to follow, valid simply stays high with the
   // next payload, so valid gets one assignment per step.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_fire) begin
            hits_sent++;
            hit_gap = ((hits_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, 4);
         end
         if (req_valid && !req_fire) begin
            // Still waiting for the block to take this beat.
         end else if (hit_gap > 0) begin
            hit_gap--;
            req_valid <= 1'b0;
         end else if (hit_q.size() != 0) begin
            req_data  <= hit_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver, falling edge. After each result it draws a random wait, except
   // in every fourth run of 64 results, where it never waits. Once, after 300
   // results, it holds off while the driver keeps offering hits, long enough
   // to fill every pipeline stage, which must pull req_ready low without
   // losing or reordering anything.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) begin
            if (!long_hold_done && results_seen >= 300) begin
               rsp_wait = 120;
               long_hold_done = 1'b1;
            end else begin
               rsp_wait = ((results_seen / 64) % 4 == 1) ? 0 : $urandom_range(0, 4);
            end
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor, rising edge: each accepted result beat is checked field by field
   // against the oldest prediction.
   always @(posedge clock) begin
      rfr_rsp_type want;
      rsp_fire <= !reset && rsp_valid && rsp_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (refracted_q.size() == 0) begin
            report_mismatch("result beat with nothing predicted", 0, 0);
         end else begin
            want = refracted_q.pop_front();
            if (rsp_data.refracted_x !== want.refracted_x)
               report_mismatch("refracted_x", $signed(rsp_data.refracted_x),
                               $signed(want.refracted_x));
            if (rsp_data.refracted_y !== want.refracted_y)
               report_mismatch("refracted_y", $signed(rsp_data.refracted_y),
                               $signed(want.refracted_y));
            if (rsp_data.refracted_z !== want.refracted_z)
               report_mismatch("refracted_z", $signed(rsp_data.refracted_z),
                               $signed(want.refracted_z));
            if (rsp_data.internal_reflection !== want.internal_reflection)
               report_mismatch("internal_reflection", rsp_data.internal_reflection,
                               want.internal_reflection);
         end
         results_seen++;
      end
   end

   // Stimulus and end of run.
   initial begin
      int kind;
      int lo;
      int span;

      // Directed hits. One unit is 16384 in Q1.14 and Q2.14.
      hit_q.push_back(hit(0, 0, 0, 0, 0, 0, 0));
      hit_q.push_back(hit(0, 0, 0, 0, 0, 0, 65535));
      // All fields at their positive extreme: the result saturates negative.
      hit_q.push_back(hit(32767, 32767, 32767, 32767, 32767, 32767, 65535));
      // All components at their negative extreme: the result saturates positive.
      hit_q.push_back(hit(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
      hit_q.push_back(hit(-32768, 32767, -32768, 32767, -32768, 32767, 65535));
      hit_q.push_back(hit(32767, -32768, 0, -32768, 32767, 0, 1));
      // Grazing incidence with eta of two is a total internal reflection.
      hit_q.push_back(hit(16384, 0, 0, 0, 16384, 0, 32768));
      // Grazing incidence with eta of one puts k at exactly zero.
      hit_q.push_back(hit(16384, 0, 0, 0, 16384, 0, 16384));
      hit_q.push_back(hit(0, -16384, 0, 0, 0, 16384, 16384));
      // Head-on incidence, into a denser and into a thinner medium.
      hit_q.push_back(hit(0, 0, -16384, 0, 0, 16384, 12288));
      hit_q.push_back(hit(0, 0, -16384, 0, 0, 16384, 21845));
      // 45 degrees: eta 1.5 reflects totally, eta 0.667 passes through.
      hit_q.push_back(hit(11585, 0, -11585, 0, 0, 16384, 24576));
      hit_q.push_back(hit(11585, 0, -11585, 0, 0, 16384, 10923));
      hit_q.push_back(hit(0, 11585, -11585, 0, 0, 16384, 23170));
      hit_q.push_back(hit(-9459, 9459, -9459, 0, 16384, 0, 16384));
      // Unnormalized vectors are taken as given.
      hit_q.push_back(hit(-20000, 5000, 31000, 1000, -30000, 12000, 40000));
      hit_q.push_back(hit(100, -1, 1, -1, 1, -100, 65535));
      hit_q.push_back(hit(16384, 16384, 16384, -16384, -16384, -16384, 0));

      // Random hits: a third with any bit pattern, a third of vectors no longer than
      // one unit with eta around one, where both outcomes of the reflection test are
      // common, and a third of short vectors with any eta.
      repeat (900) begin
         kind = $urandom_range(0, 2);
         if (kind == 0) begin
            hit_q.push_back(hit($urandom, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom));
         end else begin
            lo   = (kind == 1) ? 9459 : 2048;
            span = 2 * lo;
            hit_q.push_back(hit(int'($urandom_range(0, span)) - lo,
                                int'($urandom_range(0, span)) - lo,
                                int'($urandom_range(0, span)) - lo,
                                int'($urandom_range(0, span)) - lo,
                                int'($urandom_range(0, span)) - lo,
                                int'($urandom_range(0, span)) - lo,
                                (kind == 1) ? $urandom_range(8192, 24576)
                                            : $urandom_range(0, 65535)));
         end
      end

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Wait until every hit has been taken and every result has come back,
      // then let the pipeline drain to show any stray beat.
      while (hit_q.size() != 0 || req_valid)
         @(negedge clock);
      while (refracted_q.size() != 0)
         @(negedge clock);
      repeat (30) @(negedge clock);

      if (mismatch_count == 0 && refracted_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog, several times the slowest correct run.
   initial begin
      #200000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
